### hdl/optical_gain_smoother_macros.svh
// Assertion macros for the optical gain smoother checker.
`ifndef OPTICAL_GAIN_SMOOTHER_MACROS_SVH
`define OPTICAL_GAIN_SMOOTHER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define OGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/ogs_pkg.sv
// Shared types and constants of the optical gain smoother.
`default_nettype none

package ogs_pkg;

  localparam int VALUE_W = 24;
  localparam int COEF_W  = 24;
  localparam int INDEX_W = 7;
  localparam int CMD_W   = 2;

  localparam int DECIBEL_STEPS_DEF = 37;
  localparam int STEPS_PER_DB_DEF  = 2;

  localparam logic [COEF_W-1:0] HIST_COEF_RESET = 24'd8388568;
  localparam logic [COEF_W-1:0] COEF_ONE        = 24'd8388608;
  localparam logic [COEF_W-1:0] HIST_FRACTION   = 24'd9830;

  localparam int SHIFT_POLE = 23;
  localparam int SHIFT_FRAC = 16;
  localparam int HIST_FRAC_BITS = 24;

  // multiplier operand and accumulator widths
  localparam int MUL_A_W = COEF_W;
  localparam int MUL_B_W = 33;
  localparam int ACC_W   = 35;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROCESS    = 2'd0,
    CMD_RESET      = 2'd1,
    CMD_WR_ATTACK  = 2'd2,
    CMD_WR_RELEASE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                      valid;
    logic [MUL_A_W-1:0]        a;
    logic signed [MUL_B_W-1:0] b;
    logic signed [ACC_W-1:0]   addend;
    logic                      frac;
  } mac_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] res;
  } mac_rsp_t;

endpackage

`default_nettype wire

### hdl/ogs_if.sv
// Valid/ready channel interfaces for the smoother's input and output items.
`default_nettype none

interface ogs_in_if;
  logic                               valid;
  logic                               ready;
  logic [ogs_pkg::CMD_W-1:0]          cmd;
  logic signed [ogs_pkg::VALUE_W-1:0] value_db;
  logic [ogs_pkg::INDEX_W-1:0]        coef_index;
  logic [ogs_pkg::COEF_W-1:0]         coef_value;

  modport source (output valid, cmd, value_db, coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, value_db, coef_index, coef_value, output ready);
endinterface

interface ogs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ogs_pkg::VALUE_W-1:0] gain_reduction_db;

  modport source (output valid, gain_reduction_db, input ready);
  modport sink   (input valid, gain_reduction_db, output ready);
endinterface

`default_nettype wire

### hdl/ogs_mac.sv
// Shared two-stage multiply, round, shift and add unit.
`default_nettype none

module ogs_mac (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ogs_pkg::mac_req_t req_i,
  output ogs_pkg::mac_rsp_t      rsp_o
);
  import ogs_pkg::*;

  localparam logic signed [PROD_W-1:0] RND_POLE = PROD_W'(64'd1 << (SHIFT_POLE - 1));
  localparam logic signed [PROD_W-1:0] RND_FRAC = PROD_W'(64'd1 << (SHIFT_FRAC - 1));

  logic                    v1_q, done_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0] addend_q, res_d, res_q;
  logic                    frac_q;
  logic signed [PROD_W-1:0] rounded, shifted;

  assign prod_d = $signed({1'b0, req_i.a}) * req_i.b;

  always_comb begin
    rounded = prod_q + (frac_q ? RND_FRAC : RND_POLE);
    shifted = frac_q ? (rounded >>> SHIFT_FRAC) : (rounded >>> SHIFT_POLE);
    res_d   = addend_q + shifted[ACC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= req_i.valid;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q   <= prod_d;
      addend_q <= req_i.addend;
      frac_q   <= req_i.frac;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

`default_nettype wire

### hdl/ogs_coef_ram.sv
// Attack and release coefficient tables with a registered read port.
`default_nettype none

module ogs_coef_ram #(
  parameter int DEPTH = ogs_pkg::DECIBEL_STEPS_DEF * ogs_pkg::STEPS_PER_DB_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic                        wsel_attack_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [ogs_pkg::COEF_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic                        rsel_attack_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic [ogs_pkg::COEF_W-1:0]       rdata_o
);
  import ogs_pkg::*;

  logic [COEF_W-1:0] attack_mem  [DEPTH];
  logic [COEF_W-1:0] release_mem [DEPTH];
  logic [COEF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i && wsel_attack_i) begin
      attack_mem[waddr_i] <= wdata_i;
    end
    if (we_i && !wsel_attack_i) begin
      release_mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= rsel_attack_i ? attack_mem[raddr_i] : release_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/optical_gain_smoother.sv
// Optical gain smoother top level: sequencer, state registers and output register.
`default_nettype none

// Program-dependent attack/release smoother for gain reduction in dB (Q8.16).
// For a process item the sequencer makes three passes through one shared
// two-stage multiply-round-add unit (light history update, 0.15 times history,
// gain smoothing), with the table lookup into the coefficient memory before the
// last pass, then loads the output register and returns to idle, where the next
// item is taken. Reset, attack-write and release-write items go straight from
// the accept to loading the output register. A stalled output register holds
// the sequencer before that load and delays the next accept.
// A new item is accepted while the previous result still waits in the
// output register; a result only moves into that register once it is free.
// Tables are loaded through write items and hold no defined value until written.
module optical_gain_smoother #(
  parameter int DECIBEL_STEPS = ogs_pkg::DECIBEL_STEPS_DEF,
  parameter int STEPS_PER_DB  = ogs_pkg::STEPS_PER_DB_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [ogs_pkg::COEF_W-1:0] cfg_wdata_i,
  ogs_in_if.sink                          in_i,
  ogs_out_if.source                       out_o
);
  import ogs_pkg::*;

  localparam int TABLE_SIZE = DECIBEL_STEPS * STEPS_PER_DB;
  localparam int TAB_AW     = $clog2(TABLE_SIZE);
  localparam int STEP_W     = $clog2(STEPS_PER_DB + 1);
  localparam int DS_W       = ACC_W + STEP_W;
  localparam int IDXQ_W     = DS_W - HIST_FRAC_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_HIST   = 4'd1;
  localparam logic [3:0] ST_HIST_W = 4'd2;
  localparam logic [3:0] ST_FRAC   = 4'd3;
  localparam logic [3:0] ST_FRAC_W = 4'd4;
  localparam logic [3:0] ST_INDEX  = 4'd5;
  localparam logic [3:0] ST_CUR    = 4'd6;
  localparam logic [3:0] ST_CUR_W  = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  function automatic logic [COEF_W-1:0] coef_clamp(input logic [COEF_W-1:0] c);
    return (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

  function automatic logic signed [31:0] sat_hist(input logic signed [ACC_W-1:0] v);
    logic hi_ones, hi_zeros;
    hi_ones  = &v[ACC_W-1:31];
    hi_zeros = ~|v[ACC_W-1:31];
    if (hi_ones || hi_zeros) return v[31:0];
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [ACC_W-1:0] v);
    logic hi_ones, hi_zeros;
    hi_ones  = &v[ACC_W-1:VALUE_W-1];
    hi_zeros = ~|v[ACC_W-1:VALUE_W-1];
    if (hi_ones || hi_zeros) return v[VALUE_W-1:0];
    return v[ACC_W-1] ? 24'sh80_0000 : 24'sh7F_FFFF;
  endfunction

  logic [3:0]                state_q, state_d;
  logic [COEF_W-1:0]         hist_coef_q;
  logic signed [31:0]        lh_q, lh_d;
  logic signed [VALUE_W-1:0] cur_q, cur_d;
  logic signed [VALUE_W-1:0] x_q, x_d;
  logic signed [ACC_W-1:0]   d_q, d_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] out_data_q, out_data_d;

  logic signed [31:0]        xw;
  logic                      in_fire;
  logic                      wr_in_range;
  logic                      ram_we;
  logic [TAB_AW-1:0]         ram_waddr;
  logic [DS_W-1:0]           ds;
  logic [IDXQ_W-1:0]         idx_q_full;
  logic [TAB_AW-1:0]         tab_idx;
  logic                      use_attack;
  logic [COEF_W-1:0]         ram_rdata;
  mac_req_t                  mac_req;
  mac_rsp_t                  mac_rsp;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign xw         = {x_q, 8'h00};

  assign wr_in_range = {2'b00, in_i.coef_index} < 9'(TABLE_SIZE);
  assign ram_we      = in_fire && wr_in_range &&
                       ((cmd_e'(in_i.cmd) == CMD_WR_ATTACK) ||
                        (cmd_e'(in_i.cmd) == CMD_WR_RELEASE));
  assign ram_waddr   = TAB_AW'({2'b00, in_i.coef_index});

  // table index: floor(d * steps) in Q8.24, zero when d <= 0, saturated at the last entry
  always_comb begin
    ds         = DS_W'($unsigned(d_q)) * DS_W'(STEPS_PER_DB);
    idx_q_full = ds[DS_W-1:HIST_FRAC_BITS];
    if (d_q <= 0) begin
      tab_idx = '0;
    end else if (idx_q_full > IDXQ_W'(TABLE_SIZE - 1)) begin
      tab_idx = TAB_AW'(TABLE_SIZE - 1);
    end else begin
      tab_idx = idx_q_full[TAB_AW-1:0];
    end
  end

  assign use_attack = x_q > cur_q;

  always_comb begin
    mac_req = '0;
    case (state_q)
      ST_HIST: begin
        mac_req.valid  = 1'b1;
        mac_req.a      = coef_clamp(hist_coef_q);
        mac_req.b      = MUL_B_W'(lh_q) - MUL_B_W'(xw);
        mac_req.addend = ACC_W'(xw);
      end
      ST_FRAC: begin
        mac_req.valid = 1'b1;
        mac_req.a     = HIST_FRACTION;
        mac_req.b     = MUL_B_W'(lh_q);
        mac_req.frac  = 1'b1;
      end
      ST_CUR: begin
        mac_req.valid  = 1'b1;
        mac_req.a      = coef_clamp(ram_rdata);
        mac_req.b      = MUL_B_W'(cur_q) - MUL_B_W'(x_q);
        mac_req.addend = ACC_W'(x_q);
      end
      default: mac_req = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    lh_d        = lh_q;
    cur_d       = cur_q;
    x_d         = x_q;
    d_d         = d_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_d = in_i.value_db;
          case (cmd_e'(in_i.cmd))
            CMD_PROCESS: state_d = ST_HIST;
            CMD_RESET: begin
              cur_d   = in_i.value_db;
              lh_d    = '0;
              state_d = ST_OUT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_HIST:   state_d = ST_HIST_W;
      ST_HIST_W: begin
        if (mac_rsp.done) begin
          lh_d    = sat_hist(mac_rsp.res);
          state_d = ST_FRAC;
        end
      end
      ST_FRAC:   state_d = ST_FRAC_W;
      ST_FRAC_W: begin
        if (mac_rsp.done) begin
          d_d     = ACC_W'(xw) - mac_rsp.res;
          state_d = ST_INDEX;
        end
      end
      ST_INDEX:  state_d = ST_CUR;
      ST_CUR:    state_d = ST_CUR_W;
      ST_CUR_W: begin
        if (mac_rsp.done) begin
          cur_d   = sat_value(mac_rsp.res);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = cur_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist_coef_q <= HIST_COEF_RESET;
      lh_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lh_q        <= lh_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        hist_coef_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    d_q        <= d_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.gain_reduction_db = out_data_q;

  ogs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  ogs_coef_ram #(
    .DEPTH (TABLE_SIZE),
    .AW    (TAB_AW)
  ) u_coef_ram (
    .clk_i         (clk_i),
    .we_i          (ram_we),
    .wsel_attack_i (cmd_e'(in_i.cmd) == CMD_WR_ATTACK),
    .waddr_i       (ram_waddr),
    .wdata_i       (in_i.coef_value),
    .re_i          (state_q == ST_INDEX),
    .rsel_attack_i (use_attack),
    .raddr_i       (tab_idx),
    .rdata_o       (ram_rdata)
  );

endmodule

`default_nettype wire

### hdl/ogs_checker.sv
// Port-level checker for the optical gain smoother and its bind.
`default_nettype none

`include "optical_gain_smoother_macros.svh"

module ogs_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_i,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic signed [ogs_pkg::VALUE_W-1:0] out_data_i
);

  // a reset edge leaves no result pending at the following edge
  `OGS_ASSERT_ALWAYS(a_reset_no_out, !rst_ni |=> !out_valid_i, "result valid after reset")

  // an accepted item keeps the block busy for at least the next cycle
  `OGS_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_i) |=> !in_ready_i, "ready right after accept")

  // a new result is only produced by work in flight, never from idle
  `OGS_ASSERT(a_out_from_work, $rose(out_valid_i) |-> $past(!in_ready_i), "result appeared from idle")

  `OGS_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)), "stalled result changed")

endmodule

bind optical_gain_smoother ogs_checker u_ogs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.gain_reduction_db)
);

`default_nettype wire

### sim/optical_gain_smoother_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the optical gain smoother: directed and random items against a predictor.

module optical_gain_smoother_tb;
  import ogs_pkg::*;

  localparam int TABLE_SIZE       = DECIBEL_STEPS_DEF * STEPS_PER_DB_DEF;
  localparam int DB_Q16           = 65536;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int SETTLE_CYCLES    = 16;

  typedef logic signed [VALUE_W-1:0] db_t;
  typedef logic [COEF_W-1:0]         coef_t;
  typedef logic [INDEX_W-1:0]        index_t;

  localparam db_t DB_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam db_t DB_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  class gain_scoreboard;
    localparam longint ONE_Q23         = 64'sd8388608;
    localparam longint HIST_MIN        = -64'sd2147483648;
    localparam longint HIST_MAX        = 64'sd2147483647;
    localparam longint GAIN_MIN        = -64'sd8388608;
    localparam longint GAIN_MAX        = 64'sd8388607;
    localparam longint HIST_FRACTION_L = longint'(HIST_FRACTION);

    coef_t  hist_coef;
    longint light_history;
    longint current_reduction;
    coef_t  attack_coef[TABLE_SIZE];
    coef_t  release_coef[TABLE_SIZE];
    db_t    expected_gain[$];
    int     errors, n_checked;
    int     n_process, n_reset, n_write, n_ignored, n_attack, n_release, n_index_top;

    function new();
      hist_coef         = HIST_COEF_RESET;
      light_history     = 0;
      current_reduction = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // anything above one acts as one and freezes the pole
    function longint clip_coef(coef_t v);
      return (v > COEF_ONE) ? ONE_Q23 : longint'(v);
    endfunction

    function longint pole_step(longint c, longint old, longint x);
      return (c * old + (ONE_Q23 - c) * x + (64'sd1 <<< (SHIFT_POLE - 1))) >>> SHIFT_POLE;
    endfunction

    function int pending();
      return expected_gain.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task note_input(cmd_e cmd, db_t value, index_t index, coef_t coef);
      longint x, xw, d, sel, c;
      x = value;
      case (cmd)
        CMD_PROCESS: begin
          n_process++;
          xw = x * 256;
          light_history = clamp(pole_step(clip_coef(hist_coef), light_history, xw),
                                HIST_MIN, HIST_MAX);
          d = xw - ((light_history * HIST_FRACTION_L + (64'sd1 <<< (SHIFT_FRAC - 1)))
                    >>> SHIFT_FRAC);
          sel = (d <= 0) ? 64'sd0 : ((d * STEPS_PER_DB_DEF) >>> HIST_FRAC_BITS);
          if (sel >= TABLE_SIZE - 1) begin
            sel = TABLE_SIZE - 1;
            n_index_top++;
          end
          if (x > current_reduction) begin
            c = clip_coef(attack_coef[sel]);
            n_attack++;
          end else begin
            c = clip_coef(release_coef[sel]);
            n_release++;
          end
          current_reduction = clamp(pole_step(c, current_reduction, x), GAIN_MIN, GAIN_MAX);
        end
        CMD_RESET: begin
          n_reset++;
          current_reduction = x;
          light_history     = 0;
        end
        default: begin
          if (index < TABLE_SIZE) begin
            n_write++;
            if (cmd == CMD_WR_ATTACK) attack_coef[index] = coef;
            else release_coef[index] = coef;
          end else begin
            n_ignored++;
          end
        end
      endcase
      expected_gain.push_back(db_t'(current_reduction));
    endtask

    task check_result(db_t got);
      db_t want;
      n_checked++;
      if (expected_gain.size() == 0) begin
        report($sformatf("result %0d (%0d) arrived with nothing expected", n_checked, got));
        return;
      end
      want = expected_gain.pop_front();
      if (got !== want)
        report($sformatf("result %0d: gain_reduction_db got %0d want %0d", n_checked, got, want));
    endtask
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  cfg_we_i;
  coef_t cfg_wdata_i;

  ogs_in_if  in_ch ();
  ogs_out_if out_ch ();

  gain_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int target_level;
  int n_settings;

  optical_gain_smoother dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.gain_reduction_db);
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_op(input cmd_e cmd, input db_t value, input index_t index,
                         input coef_t coef);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = cmd;
    in_ch.value_db   = value;
    in_ch.coef_index = index;
    in_ch.coef_value = coef;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_input(cmd, value, index, coef);
    @(negedge clk_i);
  endtask

  task automatic wait_results(input int extra);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_history_coef(input coef_t v);
    cfg_wdata_i = v;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    sb.hist_coef = v;
    n_settings++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly sample streams hovering around a level that jumps now and then,
  // plus resets, table rewrites and some out-of-range noise.
  task automatic pick_random_op(output cmd_e cmd, output db_t value, output index_t index,
                                output coef_t coef);
    int r, s;
    r     = $urandom_range(0, 99);
    s     = $urandom_range(0, 99);
    value = db_t'($urandom);
    index = index_t'($urandom);
    coef  = coef_t'($urandom);
    if (r < 72) begin
      cmd = CMD_PROCESS;
      if ($urandom_range(0, 9) == 0)
        target_level = int'($urandom_range(0, 51 * DB_Q16)) - 3 * DB_Q16;
      if (s < 88)
        value = db_t'(target_level + int'($urandom_range(0, DB_Q16)) - DB_Q16 / 2);
      else if (s >= 96)
        value = (s[0]) ? DB_MAX : DB_MIN;
    end else if (r < 78) begin
      cmd = CMD_RESET;
      if (s < 60) value = db_t'(target_level + int'($urandom_range(0, 4 * DB_Q16)) - 2 * DB_Q16);
    end else begin
      cmd = (r < 89) ? CMD_WR_ATTACK : CMD_WR_RELEASE;
      if ($urandom_range(0, 99) < 88) index = index_t'($urandom_range(0, TABLE_SIZE - 1));
      else index = index_t'($urandom_range(TABLE_SIZE, 127));
      if (s < 75) coef = coef_t'($urandom_range(0, COEF_ONE));
      else if (s < 88) coef = COEF_ONE - coef_t'($urandom_range(0, DB_Q16));
      else coef = coef_t'($urandom_range(COEF_ONE, 24'hFFFFFF));
    end
  endtask

  initial begin
    cmd_e   cmd;
    db_t    value;
    index_t index;
    coef_t  coef;
    int     counted;
    bit     paused;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = '0;
    in_ch.value_db   = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    target_level     = 6 * DB_Q16;
    sb = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_pct  = (ph < 2) ? 24 : ((ph < 4) ? 58 : 0);
      recv_stall_pct = (ph < 2) ? 58 : ((ph < 4) ? 24 : 0);
      case (ph)
        0:       write_history_coef(HIST_COEF_RESET);
        1:       write_history_coef('0);
        2:       write_history_coef(COEF_ONE - coef_t'($urandom_range(1, 1 << 20)));
        3:       write_history_coef(COEF_ONE);
        4:       write_history_coef('1);
        default: write_history_coef(coef_t'($urandom_range(0, COEF_ONE)));
      endcase

      if (ph == 0) begin
        // every entry must hold a value before the first sample can read it
        for (int i = 0; i < TABLE_SIZE; i++) begin
          send_op(CMD_WR_ATTACK, db_t'($urandom), index_t'(i),
                  coef_t'($urandom_range(0, COEF_ONE)));
          send_op(CMD_WR_RELEASE, db_t'($urandom), index_t'(i),
                  coef_t'($urandom_range(0, COEF_ONE)));
        end
        send_op(CMD_RESET, '0, '0, '0);
        send_op(CMD_PROCESS, DB_MAX, '1, '1);
        send_op(CMD_PROCESS, DB_MIN, '0, '0);
        send_op(CMD_RESET, DB_MAX, '0, '0);
        send_op(CMD_PROCESS, DB_MAX, '0, '0);   // equal to current: release side
        send_op(CMD_RESET, DB_MIN, '0, '0);
        send_op(CMD_PROCESS, DB_MIN, '0, '0);
        send_op(CMD_WR_ATTACK, '0, index_t'(TABLE_SIZE), '1);   // past the table: dropped
        send_op(CMD_WR_RELEASE, '0, '1, '0);
        send_op(CMD_WR_ATTACK, '0, index_t'(TABLE_SIZE - 1), '1);
        send_op(CMD_WR_RELEASE, '0, '0, COEF_ONE);
        send_op(CMD_WR_ATTACK, '0, '0, '0);
        send_op(CMD_RESET, '0, '0, '0);
        send_op(CMD_PROCESS, db_t'(40 * DB_Q16), '0, '0);   // top entry above one: holds
        send_op(CMD_PROCESS, db_t'(-6 * DB_Q16), '0, '0);
        send_op(CMD_PROCESS, db_t'(3 * DB_Q16), '0, '0);
        send_op(CMD_WR_ATTACK, '0, index_t'(TABLE_SIZE - 1), COEF_ONE >> 1);
        send_op(CMD_PROCESS, db_t'(40 * DB_Q16), '0, '0);
        send_op(CMD_WR_RELEASE, '0, index_t'(TABLE_SIZE - 1), '0);
        send_op(CMD_RESET, DB_MAX, '0, '0);
        send_op(CMD_PROCESS, db_t'(60 * DB_Q16), '0, '0);   // zero release: jumps to target
        send_op(CMD_PROCESS, '0, '0, '0);
        send_op(CMD_PROCESS, '0, '0, '0);
      end

      counted = 0;
      paused  = 1'b0;
      while (counted < RANDOM_PER_PHASE) begin
        pick_random_op(cmd, value, index, coef);
        send_op(cmd, value, index, coef);
        if (cmd == CMD_PROCESS || cmd == CMD_RESET || index < TABLE_SIZE) counted++;
        if (!paused && counted == RANDOM_PER_PHASE / 2) begin
          wait_results(0);
          paused = 1'b1;
        end
      end
      wait_results(SETTLE_CYCLES);
    end

    $display("Covered %0d samples (%0d attack, %0d release, %0d on the last table entry), %0d resets,",
             sb.n_process, sb.n_attack, sb.n_release, sb.n_index_top, sb.n_reset);
    $display("%0d table writes, %0d dropped writes, %0d history settings, %0d results checked.",
             sb.n_write, sb.n_ignored, n_settings, sb.n_checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### optical_gain_smoother.f
+incdir+hdl
hdl/ogs_pkg.sv
hdl/ogs_if.sv
hdl/ogs_mac.sv
hdl/ogs_coef_ram.sv
hdl/optical_gain_smoother.sv
hdl/ogs_checker.sv
sim/optical_gain_smoother_tb.sv
